/* rtl/core/sbus_frame_channel_decoder_macros.svh */
// Assertion macros shared by the frame decoder checkers.
`ifndef SBUS_FRAME_CHANNEL_DECODER_MACROS_SVH
`define SBUS_FRAME_CHANNEL_DECODER_MACROS_SVH

// Consequent must hold in the cycle after the antecedent.
`define SFCD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sfcd check failed");

// Consequent must hold in the same cycle as the antecedent.
`define SFCD_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sfcd check failed");

// Checked through reset as well.
`define SFCD_ASSERT_RAW(label, clk, ante, cons) \
   label: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("sfcd check failed");

`endif

/* rtl/core/sfcd_pkg.sv */
// Types and constants of the serial frame channel decoder.
package sfcd_pkg;

   localparam int STORED_BYTES = 11;
   localparam int CHAN_COUNT   = 8;
   localparam int CHAN_BITS    = 11;
   localparam int FRAME_LEN    = 25;

   localparam logic [7:0] START_BYTE = 8'h0F;

   typedef logic [4:0]                  pos_type;
   typedef logic [3:0]                  store_idx_type;
   typedef logic [2:0]                  chan_idx_type;
   typedef logic [7:0]                  byte_type;
   typedef logic [CHAN_BITS-1:0]        chan_value_type;
   typedef logic [STORED_BYTES*8-1:0]   frame_flat_type;

   localparam pos_type LAST_POS   = pos_type'(FRAME_LEN - 1);
   localparam pos_type LAST_STORE = pos_type'(STORED_BYTES);
   localparam chan_idx_type LAST_CHAN = chan_idx_type'(CHAN_COUNT - 1);

endpackage

/* rtl/core/sfcd_unpack.sv */
// Selects one packed 11-bit channel out of the stored frame bytes.
module sfcd_unpack (
   input  sfcd_pkg::frame_flat_type frame_flat,
   input  sfcd_pkg::chan_idx_type   chan_idx,
   output sfcd_pkg::chan_value_type chan_value
);
   import sfcd_pkg::*;

   chan_value_type chan_vals [CHAN_COUNT];

   // Channels are little-endian bit fields laid back to back.
   always_comb begin
      for (int k = 0; k < CHAN_COUNT; k++) begin
         chan_vals[k] = frame_flat[k*CHAN_BITS +: CHAN_BITS];
      end
   end

   assign chan_value = chan_vals[chan_idx];

endmodule

/* rtl/core/sbus_frame_channel_decoder.sv */
// Top level of the serial frame channel decoder.
//
//   channel   direction  words               handshake
//   req_      in         one frame byte      req_valid / req_ready
//   rsp_      out        one channel result  rsp_valid / rsp_ready
//
// A byte is taken every cycle; a frame end starts eight result words from a
// snapshot register, one per cycle unless rsp_ready stalls, so the next frame
// streams in meanwhile. req_ready drops only when a frame end arrives while the
// previous frame's results are still going out.
// Reset is synchronous and returns the frame position to zero.
module sbus_frame_channel_decoder (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   input  sfcd_pkg::byte_type       req_rx_byte,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output logic [3:0]               rsp_channel_number,
   output sfcd_pkg::chan_value_type rsp_channel_value,
   output logic                     rsp_last_channel
);
   import sfcd_pkg::*;

   pos_type        pos_ff, pos_in;
   byte_type       frame_ff [STORED_BYTES];
   frame_flat_type frame_flat;
   frame_flat_type snap_ff;
   logic           pending_ff, pending_in;
   chan_idx_type   cnt_ff, cnt_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [3:0]     number_ff;
   chan_value_type value_ff;
   logic           last_ff;
   chan_value_type chan_value;
   logic           take, frame_end, emit;
   store_idx_type  wr_idx;

   assign req_ready = !(pending_ff && pos_ff == LAST_POS);
   assign take      = req_valid && req_ready;
   assign frame_end = take && pos_ff == LAST_POS;
   assign emit      = pending_ff && (!rsp_valid_ff || rsp_ready);
   assign wr_idx    = store_idx_type'(pos_ff - pos_type'(1));

   always_comb begin
      for (int i = 0; i < STORED_BYTES; i++) begin
         frame_flat[i*8 +: 8] = frame_ff[i];
      end
   end

   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         if (pos_ff == '0) begin
            // hunt for the start byte
            if (req_rx_byte == START_BYTE) pos_in = pos_type'(1);
         end else if (pos_ff == LAST_POS) begin
            pos_in = '0;
         end else begin
            pos_in = pos_ff + pos_type'(1);
         end
      end
   end

   always_comb begin
      pending_in   = pending_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_ready) rsp_valid_in = 1'b0;
      if (emit) begin
         rsp_valid_in = 1'b1;
         cnt_in       = cnt_ff + chan_idx_type'(1);
         if (cnt_ff == LAST_CHAN) pending_in = 1'b0;
      end
      if (frame_end) begin
         pending_in = 1'b1;
         cnt_in     = '0;
      end
   end

   sfcd_unpack u_unpack (
      .frame_flat (snap_ff),
      .chan_idx   (cnt_ff),
      .chan_value (chan_value)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff       <= '0;
         pending_ff   <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         pos_ff       <= pos_in;
         pending_ff   <= pending_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pos_ff != '0 && pos_ff <= LAST_STORE) begin
         frame_ff[wr_idx] <= req_rx_byte;
      end
      if (frame_end) snap_ff <= frame_flat;
      if (emit) begin
         number_ff <= {1'b0, cnt_ff} + 4'd1;
         value_ff  <= chan_value;
         last_ff   <= (cnt_ff == LAST_CHAN);
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_channel_number = number_ff;
   assign rsp_channel_value  = value_ff;
   assign rsp_last_channel   = last_ff;

endmodule

/* rtl/core/sfcd_checker.sv */
// Port-level checks for the serial frame channel decoder, with its bind.
`include "sbus_frame_channel_decoder_macros.svh"

module sfcd_checker (
   input logic                     clock,
   input logic                     reset,
   input logic                     rsp_valid,
   input logic                     rsp_ready,
   input logic [3:0]               rsp_channel_number,
   input sfcd_pkg::chan_value_type rsp_channel_value,
   input logic                     rsp_last_channel
);

   logic       rsp_stall;
   logic       step_from;
   logic       number_is_eight;
   logic       number_ok;
   logic [3:0] want_number_ff, want_number_in;

   assign rsp_stall       = rsp_valid && !rsp_ready;
   assign step_from       = rsp_valid && rsp_ready && !rsp_last_channel;
   assign number_is_eight = (rsp_channel_number == 4'd8);
   assign want_number_in  = rsp_channel_number + 4'd1;
   assign number_ok       = !rsp_valid || (rsp_channel_number == want_number_ff);

   always_ff @(posedge clock) begin
      want_number_ff <= want_number_in;
   end

   `SFCD_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_stall, rsp_valid)
   `SFCD_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_stall, $stable(rsp_channel_value))
   `SFCD_ASSERT_NOW(a_last_is_eighth, clock, reset, rsp_valid, rsp_last_channel == number_is_eight)
   `SFCD_ASSERT_NEXT(a_number_steps, clock, reset, step_from, number_ok)
   `SFCD_ASSERT_RAW(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind sbus_frame_channel_decoder sfcd_checker u_sfcd_checker (.*);

/* verif/sbus_frame_channel_decoder_test.sv */
// Self-checking bench for the frame decoder: random byte streams, channel words checked in order.
`timescale 1ns / 1ps

module sbus_frame_channel_decoder_test;
   import sfcd_pkg::*;

   localparam int REQ_SIDE       = 0;
   localparam int RSP_SIDE       = 1;
   localparam int MAX_WAIT       = 17;
   localparam int RANDOM_ITEMS   = 90;
   localparam int DRAIN_CYCLES   = 16;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef struct packed {
      logic [3:0]     number;
      chan_value_type value;
      logic           last;
   } channel_word_type;

   logic           clock;
   logic           reset = 1'b1;
   logic           req_valid = 1'b0;
   logic           req_ready;
   byte_type       req_rx_byte = '0;
   logic           rsp_valid;
   logic           rsp_ready = 1'b0;
   logic [3:0]     rsp_channel_number;
   chan_value_type rsp_channel_value;
   logic           rsp_last_channel;

   byte_type         pending_bytes[$];
   channel_word_type expected_channels[$];
   channel_word_type oldest_word;

   pos_type  frame_pos = '0;
   byte_type frame_store[STORED_BYTES];

   int unsigned req_hold;
   int unsigned rsp_hold;
   int unsigned rsp_draw;
   int unsigned run_left[2] = '{0, 0};
   bit          calm_run[2] = '{0, 0};
   int unsigned idle_cycles = 0;
   int          mismatches = 0;

   sbus_frame_channel_decoder DUT (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_rx_byte        (req_rx_byte),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_channel_number (rsp_channel_number),
      .rsp_channel_value  (rsp_channel_value),
      .rsp_last_channel   (rsp_last_channel)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Wait before the next word; each run is drawn as either random waits or no waits at all.
   function automatic int unsigned next_wait(int side);
      if (run_left[side] == 0) begin
         calm_run[side] = ($urandom_range(0, 2) == 0);
         run_left[side] = $urandom_range(10, 40);
      end
      run_left[side] = run_left[side] - 1;
      return calm_run[side] ? 0 : $urandom_range(0, MAX_WAIT);
   endfunction

   // Track the frame position; on the last byte unpack eight 11-bit channels from bytes 1 to 11.
   task automatic predict_byte(input byte_type rx);
      frame_flat_type   packed_bytes;
      channel_word_type word;
      if (frame_pos == '0 && rx != START_BYTE)
         return;
      if (frame_pos >= 1 && frame_pos <= LAST_STORE)
         frame_store[frame_pos - 1] = rx;
      if (frame_pos != LAST_POS) begin
         frame_pos = frame_pos + 1'b1;
         return;
      end
      frame_pos = '0;
      for (int i = 0; i < STORED_BYTES; i++)
         packed_bytes[8*i +: 8] = frame_store[i];
      for (int k = 0; k < CHAN_COUNT; k++) begin
         word.number = 4'(k + 1);
         word.value  = packed_bytes[CHAN_BITS*k +: CHAN_BITS];
         word.last   = (k == CHAN_COUNT - 1);
         expected_channels.push_back(word);
      end
   endtask

   // Driver: present the next byte once the wait drawn for it has run out.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_hold  <= next_wait(REQ_SIDE);
      end else if (!req_valid || req_ready) begin
         if (req_hold != 0) begin
            req_valid <= 1'b0;
            req_hold  <= req_hold - 1;
         end else if (pending_bytes.size() != 0) begin
            req_valid   <= 1'b1;
            req_rx_byte <= pending_bytes.pop_front();
            req_hold    <= next_wait(REQ_SIDE);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Result side: stall for a drawn number of cycles after each word taken.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_hold  <= next_wait(RSP_SIDE);
      end else if (rsp_valid && rsp_ready) begin
         rsp_draw = next_wait(RSP_SIDE);
         rsp_hold  <= rsp_draw;
         rsp_ready <= (rsp_draw == 0);
      end else if (rsp_hold != 0) begin
         rsp_hold  <= rsp_hold - 1;
         rsp_ready <= (rsp_hold == 1);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Monitor: predict from accepted bytes first, then check the accepted channel word.
   always @(posedge clock) begin
      if (reset) begin
         frame_pos = '0;
      end else begin
         if (req_valid && req_ready)
            predict_byte(req_rx_byte);
         if (rsp_valid && rsp_ready) begin
            if (expected_channels.size() == 0) begin
               $error("unexpected channel word: channel_number %0d channel_value %0d",
                      rsp_channel_number, rsp_channel_value);
               mismatches++;
            end else begin
               oldest_word = expected_channels.pop_front();
               if (oldest_word.number !== rsp_channel_number) begin
                  $error("channel_number: expected %0d, actual %0d",
                         oldest_word.number, rsp_channel_number);
                  mismatches++;
               end
               if (oldest_word.value !== rsp_channel_value) begin
                  $error("channel_value: expected %0d, actual %0d",
                         oldest_word.value, rsp_channel_value);
                  mismatches++;
               end
               if (oldest_word.last !== rsp_last_channel) begin
                  $error("last_channel: expected %0d, actual %0d",
                         oldest_word.last, rsp_last_channel);
                  mismatches++;
               end
            end
         end
      end
   end

   // Watchdog: count cycles in which no word moves on either side.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("TEST FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      static byte_type directed_frame[FRAME_LEN] = '{
         8'h0F,
         8'hFF, 8'h07, 8'h00, 8'h00, 8'h0F, 8'hF0, 8'h00, 8'hFF, 8'hFF, 8'hFF, 8'h00,
         8'h0F, 8'h00, 8'hFF, 8'h0F, 8'h00, 8'h0F, 8'hFF, 8'h00, 8'h0F, 8'hFF, 8'h00,
         8'h0F, 8'h00
      };
      byte_type rx;
      int       body_len;
      int       counted;

      // Directed: noise while hunting for the start byte, then one frame with extreme
      // channel values and 0x0F both among the stored bytes and in the unchecked tail.
      pending_bytes.push_back(8'h00);
      pending_bytes.push_back(8'hFF);
      pending_bytes.push_back(8'h0E);
      pending_bytes.push_back(8'hF0);
      foreach (directed_frame[i])
         pending_bytes.push_back(directed_frame[i]);

      // Random: mostly whole frames, some cut short, with noise bursts between them.
      counted = 0;
      while (counted < RANDOM_ITEMS) begin
         if ($urandom_range(0, 4) == 0) begin
            repeat ($urandom_range(1, 4)) begin
               rx = byte_type'($urandom_range(0, 255));
               if (rx == START_BYTE)
                  rx = ~rx;
               pending_bytes.push_back(rx);
               counted++;
            end
         end
         body_len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, FRAME_LEN - 2)
                                                : FRAME_LEN - 1;
         pending_bytes.push_back(START_BYTE);
         counted++;
         repeat (body_len) begin
            case ($urandom_range(0, 9))
               0: begin
                  rx = START_BYTE;
               end
               1: begin
                  rx = 8'h00;
               end
               2: begin
                  rx = 8'hFF;
               end
               default: begin
                  rx = byte_type'($urandom_range(0, 255));
               end
            endcase
            pending_bytes.push_back(rx);
            counted++;
         end
      end

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      while (pending_bytes.size() != 0 || req_valid)
         @(negedge clock);
      while (expected_channels.size() != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (mismatches == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule
